// ===== hdl/ppr_pkg.sv =====
// Shared types and constants for the pixel palette recolor block.
// Holds the pipeline item structure, effect and register codes, and the
// grayscale reciprocal constants. No dependencies.
`timescale 1ns / 1ps

package ppr_pkg;

    // Number of palette slots, one cell per slot.
    localparam int TABLE_ENTRIES = 12;

    // Fixed field widths.
    localparam int CHAN_W  = 8;
    localparam int RGB_W   = 24;
    localparam int ENTRY_W = 4;
    localparam int COUNT_W = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    // Slot numbers are compared at a width that holds every slot and every entry index.
    localparam int SLOT_W = ($clog2(TABLE_ENTRIES) > ENTRY_W) ? $clog2(TABLE_ENTRIES) : ENTRY_W;

    // Weighted luma sum 30R + 59G + 11B stays below 2^15.
    localparam int SUM_W  = 15;
    localparam int MUL_W  = 13;
    localparam int PROD_W = SUM_W + MUL_W;
    // Division by 100 as multiply by 5243 and shift right by 19; exact for sums up to 25500.
    localparam logic [MUL_W-1:0] GRAY_MUL = MUL_W'(5243);
    localparam int GRAY_SHIFT = 19;
    localparam logic [SUM_W-1:0] WEIGHT_R = SUM_W'(30);
    localparam logic [SUM_W-1:0] WEIGHT_G = SUM_W'(59);
    localparam logic [SUM_W-1:0] WEIGHT_B = SUM_W'(11);

    typedef enum logic [1:0] {
        EFF_PASS    = 2'd0,
        EFF_INVERT  = 2'd1,
        EFF_GRAY    = 2'd2,
        EFF_PALETTE = 2'd3
    } t_effect;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BACKGROUND = 2'd0,
        CFG_EFFECT     = 2'd1,
        CFG_COUNT      = 2'd2
    } t_cfg;

    typedef enum logic {
        MODE_PIXEL = 1'b0,
        MODE_WRITE = 1'b1
    } t_mode;

    // One item moving down the cell chain. For a table write, rgb carries the
    // match color and rep the replacement color; for a pixel, rep carries the
    // replacement picked up by the first matching cell.
    typedef struct packed {
        logic               valid;
        t_mode              mode;
        logic [RGB_W-1:0]   rgb;
        logic [CHAN_W-1:0]  alpha;
        logic               apply;
        logic               pal;
        logic [SUM_W-1:0]   sum;
        logic [ENTRY_W-1:0] index;
        logic               hit;
        logic [RGB_W-1:0]   rep;
    } t_item;

endpackage

// ===== hdl/pixel_palette_recolor.sv =====
// A pixel is registered in the input stage at the accepting edge, then passes one stage per
// palette cell and a final output stage before it appears on the output.
// Throughput: one item per cycle; a stalled output transfer halts the whole cell chain.
// Reset clears the configuration registers and all stage valid flags; palette slots
// hold no defined value until a table write reaches them.
// Top level of the pixel palette recolor block; depends on ppr_pkg, ppr_cell, ppr_post.
`timescale 1ns / 1ps

module pixel_palette_recolor
    import ppr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Input item channel
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_mode,
    input  logic [CHAN_W-1:0]     i_pixel_red,
    input  logic [CHAN_W-1:0]     i_pixel_green,
    input  logic [CHAN_W-1:0]     i_pixel_blue,
    input  logic [CHAN_W-1:0]     i_pixel_alpha,
    input  logic [ENTRY_W-1:0]    i_entry_index,
    input  logic [RGB_W-1:0]      i_match_rgb,
    input  logic [RGB_W-1:0]      i_replace_rgb,
    // Result channel
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [CHAN_W-1:0]     o_out_red,
    output logic [CHAN_W-1:0]     o_out_green,
    output logic [CHAN_W-1:0]     o_out_blue,
    output logic [CHAN_W-1:0]     o_out_alpha,
    // Configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic               r_out_valid;
    logic               w_en;
    logic [RGB_W-1:0]   r_background;
    t_effect            r_effect;
    logic [COUNT_W-1:0] r_count;
    t_item              r_head;
    t_item              n_head;
    logic [RGB_W-1:0]   w_pix_rgb;
    t_item              w_chain [TABLE_ENTRIES+1];
    logic [TABLE_ENTRIES-1:0] w_active;

    // The chain advances unless a finished result is waiting.
    assign w_en       = !r_out_valid || i_out_ready;
    assign o_in_ready = w_en;
    assign o_out_valid = r_out_valid;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_background <= '0;
            r_effect     <= EFF_PASS;
            r_count      <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_BACKGROUND: r_background <= i_cfg_data[RGB_W-1:0];
                CFG_EFFECT:     r_effect     <= t_effect'(i_cfg_data[1:0]);
                CFG_COUNT:      r_count      <= i_cfg_data[COUNT_W-1:0];
                default:        ;
            endcase
        end
    end

    // Input stage: key test and weighted luma sum.
    assign w_pix_rgb = {i_pixel_red, i_pixel_green, i_pixel_blue};

    always_comb begin
        n_head       = '0;
        n_head.valid = i_in_valid;
        n_head.mode  = t_mode'(i_mode);
        n_head.alpha = i_pixel_alpha;
        n_head.index = i_entry_index;
        n_head.hit   = 1'b0;
        if (t_mode'(i_mode) == MODE_WRITE) begin
            n_head.rgb = i_match_rgb;
            n_head.rep = i_replace_rgb;
        end else begin
            n_head.rgb = w_pix_rgb;
            n_head.rep = '0;
        end
        n_head.apply = (i_pixel_alpha != '0) && (w_pix_rgb != r_background);
        n_head.pal   = n_head.apply && (r_effect == EFF_PALETTE);
        n_head.sum   = SUM_W'(i_pixel_red) * WEIGHT_R
                     + SUM_W'(i_pixel_green) * WEIGHT_G
                     + SUM_W'(i_pixel_blue) * WEIGHT_B;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head.valid <= 1'b0;
        end else if (w_en) begin
            r_head <= n_head;
        end
    end

    assign w_chain[0] = r_head;

    // Row of palette cells, lowest slot first so the first match wins.
    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        assign w_active[g] = SLOT_W'(g) < SLOT_W'(r_count);

        ppr_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (w_en),
            .i_slot   (SLOT_W'(g)),
            .i_active (w_active[g]),
            .i_item   (w_chain[g]),
            .o_item   (w_chain[g+1])
        );
    end

    // Output stage.
    ppr_post u_post (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_effect (r_effect),
        .i_item   (w_chain[TABLE_ENTRIES]),
        .o_valid  (r_out_valid),
        .o_red    (o_out_red),
        .o_green  (o_out_green),
        .o_blue   (o_out_blue),
        .o_alpha  (o_out_alpha)
    );

`ifndef SYNTHESIS
    // Input is refused only while a result waits on a stalled output.
    a_ready_only_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (o_out_valid && !i_out_ready))
        else $error("input refused without an output stall");

    // A table write leaving the chain never becomes a result.
    a_write_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en && w_chain[TABLE_ENTRIES].valid && (w_chain[TABLE_ENTRIES].mode == MODE_WRITE))
        |=> !o_out_valid)
        else $error("table write produced a result");

    // A palette hit is only ever taken by a pixel that asked for replacement.
    a_hit_needs_pal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_chain[TABLE_ENTRIES].valid && w_chain[TABLE_ENTRIES].hit)
        |-> (w_chain[TABLE_ENTRIES].pal && (w_chain[TABLE_ENTRIES].mode == MODE_PIXEL)))
        else $error("palette hit on an item without replacement");

    // An accepted pixel with no stall reaches the first cell in the next cycle.
    a_head_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_head.valid)
        else $error("accepted item lost at the input stage");
`endif

endmodule

// ===== hdl/ppr_cell.sv =====
// One palette cell: holds a match/replacement pair and passes items to its neighbor.
// Depends on ppr_pkg for the item structure.
`timescale 1ns / 1ps

module ppr_cell
    import ppr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic [SLOT_W-1:0] i_slot,
    input  logic              i_active,
    input  t_item             i_item,
    output t_item             o_item
);

    logic [RGB_W-1:0] r_match;
    logic [RGB_W-1:0] r_replace;
    t_item            r_item;
    t_item            n_item;
    logic             w_write;

    assign w_write = i_item.valid && (i_item.mode == MODE_WRITE)
                     && (SLOT_W'(i_item.index) == i_slot);

    // A pixel that has not hit yet picks up this slot's replacement on a match.
    always_comb begin
        n_item = i_item;
        if (i_item.valid && (i_item.mode == MODE_PIXEL) && i_item.pal && !i_item.hit
            && i_active && (r_match == i_item.rgb)) begin
            n_item.hit = 1'b1;
            n_item.rep = r_replace;
        end
    end

    // Table storage is loaded when a write item for this slot passes this cell.
    always_ff @(posedge i_clk) begin
        if (i_en && w_write) begin
            r_match   <= i_item.rgb;
            r_replace <= i_item.rep;
        end
    end

    // Stage register toward the next cell.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item.valid <= 1'b0;
        end else if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_item = r_item;

endmodule

// ===== hdl/ppr_post.sv =====
// Output stage: applies the selected effect and holds the result transfer.
// Depends on ppr_pkg for the item structure and grayscale constants.
`timescale 1ns / 1ps

module ppr_post
    import ppr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  t_effect           i_effect,
    input  t_item             i_item,
    output logic              o_valid,
    output logic [CHAN_W-1:0] o_red,
    output logic [CHAN_W-1:0] o_green,
    output logic [CHAN_W-1:0] o_blue,
    output logic [CHAN_W-1:0] o_alpha
);

    logic              r_valid;
    logic [RGB_W-1:0]  r_rgb;
    logic [CHAN_W-1:0] r_alpha;
    logic [RGB_W-1:0]  n_rgb;
    logic [PROD_W-1:0] w_prod;
    logic [CHAN_W-1:0] w_gray;

    // Divide the weighted sum by 100 through the reciprocal product.
    assign w_prod = PROD_W'(i_item.sum) * PROD_W'(GRAY_MUL);
    assign w_gray = w_prod[GRAY_SHIFT +: CHAN_W];

    // Effect selection; keyed and transparent pixels pass unchanged.
    always_comb begin
        n_rgb = i_item.rgb;
        if (i_item.apply) begin
            case (i_effect)
                EFF_PASS:    n_rgb = i_item.rgb;
                EFF_INVERT:  n_rgb = ~i_item.rgb;
                EFF_GRAY:    n_rgb = {w_gray, w_gray, w_gray};
                EFF_PALETTE: n_rgb = i_item.hit ? i_item.rep : i_item.rgb;
                default:     n_rgb = i_item.rgb;
            endcase
        end
    end

    // Result register; table writes leave no result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_item.valid && (i_item.mode == MODE_PIXEL);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rgb   <= n_rgb;
            r_alpha <= i_item.alpha;
        end
    end

    assign o_valid = r_valid;
    assign o_red   = r_rgb[2*CHAN_W +: CHAN_W];
    assign o_green = r_rgb[CHAN_W +: CHAN_W];
    assign o_blue  = r_rgb[0 +: CHAN_W];
    assign o_alpha = r_alpha;

endmodule

// ===== test/tb_pixel_palette_recolor.sv =====
// Self-checking testbench for pixel_palette_recolor: directed and random RGBA
// streams with table writes, checked against an in-bench recolor predictor.
// Depends on ppr_pkg and the pixel_palette_recolor RTL.
`timescale 1ns / 1ps

module tb_pixel_palette_recolor
    import ppr_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 30;
    localparam int HOLD_CYCLES    = 240;

    // One input transfer, pixel and table fields side by side.
    typedef struct {
        t_mode             mode;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] alpha;
        logic [ENTRY_W-1:0] slot;
        logic [RGB_W-1:0]  match_c;
        logic [RGB_W-1:0]  repl_c;
    } t_pix_item;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] alpha;
    } t_rgba;

    typedef enum logic [1:0] {
        RX_ALWAYS   = 2'd0,
        RX_MOSTLY   = 2'd1,
        RX_SPARSE   = 2'd2,
        RX_PERIODIC = 2'd3
    } t_rx_style;

    // Clock, reset and block inputs, all known from time zero.
    logic                  clk;
    logic                  rst_n       = 1'b0;
    logic                  in_valid    = 1'b0;
    logic                  in_mode     = MODE_PIXEL;
    logic [CHAN_W-1:0]     in_red      = '0;
    logic [CHAN_W-1:0]     in_green    = '0;
    logic [CHAN_W-1:0]     in_blue     = '0;
    logic [CHAN_W-1:0]     in_alpha    = '0;
    logic [ENTRY_W-1:0]    in_slot     = '0;
    logic [RGB_W-1:0]      in_match    = '0;
    logic [RGB_W-1:0]      in_repl     = '0;
    logic                  out_ready   = 1'b0;
    logic                  cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = CFG_BACKGROUND;
    logic [CFG_DATA_W-1:0] cfg_data    = '0;

    logic                  in_ready;
    logic                  out_valid;
    logic [CHAN_W-1:0]     out_red;
    logic [CHAN_W-1:0]     out_green;
    logic [CHAN_W-1:0]     out_blue;
    logic [CHAN_W-1:0]     out_alpha;

    // Predictor state: palette tables and register mirrors.
    logic [RGB_W-1:0]   match_tbl [TABLE_ENTRIES];
    logic [RGB_W-1:0]   repl_tbl  [TABLE_ENTRIES];
    logic [RGB_W-1:0]   bg_key     = '0;
    t_effect            effect_reg = EFF_PASS;
    logic [COUNT_W-1:0] count_reg  = '0;

    t_rgba expected_pixels [$];
    int    error_count = 0;
    int    burst_left  = 0;
    bit    hold_request = 1'b0;

    // Colors picked in the directed table load and reused later.
    logic [RGB_W-1:0] dup_color;
    logic [RGB_W-1:0] ghost_color;

    pixel_palette_recolor DUT (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_mode        (in_mode),
        .i_pixel_red   (in_red),
        .i_pixel_green (in_green),
        .i_pixel_blue  (in_blue),
        .i_pixel_alpha (in_alpha),
        .i_entry_index (in_slot),
        .i_match_rgb   (in_match),
        .i_replace_rgb (in_repl),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_out_red     (out_red),
        .o_out_green   (out_green),
        .o_out_blue    (out_blue),
        .o_out_alpha   (out_alpha),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    // 50 MHz clock.
    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Recolor predictor: updates the tables on a write, queues the expected pixel otherwise.
    function automatic void recolor_predict(input t_pix_item it);
        t_rgba            res;
        logic [RGB_W-1:0] rgb;
        int               sum;
        int               limit;
        bit               found;
        if (it.mode == MODE_WRITE) begin
            if (it.slot < TABLE_ENTRIES) begin
                match_tbl[it.slot] = it.match_c;
                repl_tbl[it.slot]  = it.repl_c;
            end
            return;
        end
        res   = '{it.red, it.green, it.blue, it.alpha};
        rgb   = {it.red, it.green, it.blue};
        found = 1'b0;
        if (it.alpha != 0 && rgb != bg_key) begin
            case (effect_reg)
                EFF_INVERT: begin
                    res.red   = 8'd255 - it.red;
                    res.green = 8'd255 - it.green;
                    res.blue  = 8'd255 - it.blue;
                end
                EFF_GRAY: begin
                    sum       = 30 * it.red + 59 * it.green + 11 * it.blue;
                    res.red   = CHAN_W'(sum / 100);
                    res.green = res.red;
                    res.blue  = res.red;
                end
                EFF_PALETTE: begin
                    limit = (count_reg > TABLE_ENTRIES) ? TABLE_ENTRIES : count_reg;
                    for (int i = 0; i < limit; i++) begin
                        if (!found && match_tbl[i] == rgb) begin
                            found     = 1'b1;
                            res.red   = repl_tbl[i][23:16];
                            res.green = repl_tbl[i][15:8];
                            res.blue  = repl_tbl[i][7:0];
                        end
                    end
                end
                default: ;
            endcase
        end
        expected_pixels = {expected_pixels, res};
    endfunction

    // Pixel item; the table fields carry noise the block must ignore.
    function automatic t_pix_item make_pixel(input logic [RGB_W-1:0] rgb,
                                             input logic [CHAN_W-1:0] alpha);
        t_pix_item it;
        it.mode    = MODE_PIXEL;
        it.red     = rgb[23:16];
        it.green   = rgb[15:8];
        it.blue    = rgb[7:0];
        it.alpha   = alpha;
        it.slot    = ENTRY_W'($urandom());
        it.match_c = RGB_W'($urandom());
        it.repl_c  = RGB_W'($urandom());
        return it;
    endfunction

    // Table write item; the pixel fields carry noise.
    function automatic t_pix_item make_write(input logic [ENTRY_W-1:0] slot,
                                             input logic [RGB_W-1:0] match_c,
                                             input logic [RGB_W-1:0] repl_c);
        t_pix_item it;
        it.mode    = MODE_WRITE;
        it.red     = CHAN_W'($urandom());
        it.green   = CHAN_W'($urandom());
        it.blue    = CHAN_W'($urandom());
        it.alpha   = CHAN_W'($urandom());
        it.slot    = slot;
        it.match_c = match_c;
        it.repl_c  = repl_c;
        return it;
    endfunction

    // Random item, one in ten a table write; pixels biased toward table hits, key hits and transparent pixels.
    function automatic t_pix_item random_item();
        logic [RGB_W-1:0]  rgb;
        logic [CHAN_W-1:0] alpha;
        int                pick;
        if ($urandom_range(0, 9) == 0) begin
            pick = $urandom_range(0, 7);
            rgb  = ($urandom_range(0, 1) == 0) ? RGB_W'($urandom())
                                                : match_tbl[$urandom_range(0, TABLE_ENTRIES - 1)];
            return make_write((pick == 0) ? ENTRY_W'($urandom_range(TABLE_ENTRIES, 15))
                                          : ENTRY_W'($urandom_range(0, TABLE_ENTRIES - 1)),
                              rgb, RGB_W'($urandom()));
        end
        pick = $urandom_range(0, 19);
        if (pick < 7)
            rgb = match_tbl[$urandom_range(0, TABLE_ENTRIES - 1)];
        else if (pick < 9)
            rgb = bg_key;
        else if (pick == 9)
            rgb = '0;
        else if (pick == 10)
            rgb = '1;
        else
            rgb = RGB_W'($urandom());
        pick = $urandom_range(0, 19);
        if (pick < 2)
            alpha = '0;
        else if (pick == 2)
            alpha = '1;
        else
            alpha = CHAN_W'($urandom_range(0, 255));
        return make_pixel(rgb, alpha);
    endfunction

    // Offer one item in the sender's burst pattern and wait for its transfer.
    // Called and returning at a rising edge.
    task automatic offer_item(input t_pix_item it);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_mode  <= it.mode;
        in_red   <= it.red;
        in_green <= it.green;
        in_blue  <= it.blue;
        in_alpha <= it.alpha;
        in_slot  <= it.slot;
        in_match <= it.match_c;
        in_repl  <= it.repl_c;
        // Ready is stable by the falling edge, so the transfer is known there.
        @(negedge clk);
        while (!in_ready) @(negedge clk);
        @(posedge clk);
        recolor_predict(it);
    endtask

    // Register write; the predictor mirror follows at the write edge.
    task automatic write_register(input t_cfg idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_BACKGROUND: bg_key     = data[RGB_W-1:0];
            CFG_EFFECT:     effect_reg = t_effect'(data[1:0]);
            CFG_COUNT:      count_reg  = data[COUNT_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // Effect and count writes carry junk in the unused upper bits.
    task automatic set_recolor(input t_effect eff, input logic [COUNT_W-1:0] cnt);
        write_register(CFG_EFFECT, {22'($urandom()), eff});
        write_register(CFG_COUNT, {20'($urandom()), cnt});
    endtask

    // Stop offering and wait until every expected pixel has come back.
    task automatic await_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_pixels.size() != 0) @(posedge clk);
    endtask

    // Full quiet point: results drained and trailing table writes settled.
    task automatic wait_quiet();
        await_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Load every slot before any search can reach it, plus two ignored writes.
    task automatic test_table_load();
        logic [RGB_W-1:0] color;
        dup_color   = RGB_W'($urandom());
        ghost_color = RGB_W'($urandom());
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (i == 0)
                color = '0;
            else if (i == 3 || i == 7)
                color = dup_color;
            else if (i == TABLE_ENTRIES - 1)
                color = '1;
            else
                color = RGB_W'($urandom());
            offer_item(make_write(ENTRY_W'(i), color, RGB_W'($urandom())));
        end
        offer_item(make_write(ENTRY_W'(TABLE_ENTRIES), ghost_color, RGB_W'($urandom())));
        offer_item(make_write(4'hF, ghost_color, RGB_W'($urandom())));
    endtask

    // Reset settings: pass effect with a black key; transparent and keyed pixels.
    task automatic test_pass_and_keys();
        offer_item(make_pixel(24'h000000, 8'd7));
        offer_item(make_pixel(24'hFFFFFF, 8'd0));
        offer_item(make_pixel(24'hFF8001, 8'd255));
    endtask

    // Invert with a white key.
    task automatic test_invert();
        wait_quiet();
        write_register(CFG_BACKGROUND, 24'hFFFFFF);
        set_recolor(EFF_INVERT, 4'd0);
        offer_item(make_pixel(24'h000000, 8'd255));
        offer_item(make_pixel(24'hFFFFFF, 8'd128));
        offer_item(make_pixel(24'h5AA5C3, 8'd0));
        offer_item(make_pixel(24'h5AA5C3, 8'd1));
    endtask

    // Grayscale at the top of the weighted sum and at small values.
    task automatic test_grayscale();
        wait_quiet();
        write_register(CFG_BACKGROUND, 24'h0A0B0C);
        set_recolor(EFF_GRAY, 4'd0);
        offer_item(make_pixel(24'hFFFFFF, 8'd255));
        offer_item(make_pixel(24'h010203, 8'd40));
        offer_item(make_pixel(24'h0A0B0C, 8'd40));
    endtask

    // Palette hits, lowest duplicate slot, a miss, oversized and zero counts.
    task automatic test_palette();
        wait_quiet();
        set_recolor(EFF_PALETTE, 4'd15);
        offer_item(make_pixel(24'h000000, 8'd9));
        offer_item(make_pixel(dup_color, 8'd200));
        offer_item(make_pixel(24'hFFFFFF, 8'd255));
        offer_item(make_pixel(ghost_color, 8'd3));
        wait_quiet();
        write_register(CFG_COUNT, 24'd0);
        offer_item(make_pixel(24'h000000, 8'd9));
        wait_quiet();
        write_register(CFG_COUNT, 24'(TABLE_ENTRIES));
        offer_item(make_pixel(24'hFFFFFF, 8'd77));
    endtask

    // Receiver holds off for a long stretch while the sender keeps offering.
    task automatic test_backpressure();
        wait_quiet();
        set_recolor(EFF_PALETTE, 4'(TABLE_ENTRIES));
        hold_request = 1'b1;
        burst_left   = 80;
        for (int n = 0; n < 60; n++)
            offer_item(random_item());
    endtask

    // Random phases over a spread of register settings.
    task automatic test_random_phases();
        int               count_plan [8] = '{12, 0, 15, 3, 7, 12, 13, 1};
        logic [RGB_W-1:0] key;
        for (int phase = 0; phase < 8; phase++) begin
            wait_quiet();
            if (phase == 0)
                key = '0;
            else if (phase == 1)
                key = '1;
            else if ($urandom_range(0, 1) == 0)
                key = match_tbl[$urandom_range(0, TABLE_ENTRIES - 1)];
            else
                key = RGB_W'($urandom());
            write_register(CFG_BACKGROUND, key);
            set_recolor(t_effect'(phase % 4), COUNT_W'(count_plan[phase]));
            for (int n = 0; n < 125; n++) begin
                // Mid-phase pause until the pipeline is empty.
                if (phase == 4 && n == 60)
                    await_results();
                offer_item(random_item());
            end
        end
    endtask

    // Receiver: changing stall styles, plus the long hold-off on request.
    always @(posedge clk) begin : result_ready_gen
        int        style_left;
        int        hold_left;
        int        tick;
        t_rx_style style;
        if (hold_request && hold_left == 0) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (style_left == 0) begin
            style_left = $urandom_range(40, 300);
            style      = t_rx_style'($urandom_range(0, 3));
        end
        style_left--;
        tick++;
        if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else begin
            case (style)
                RX_ALWAYS:   out_ready <= 1'b1;
                RX_MOSTLY:   out_ready <= ($urandom_range(0, 3) != 0);
                RX_SPARSE:   out_ready <= ($urandom_range(0, 9) < 3);
                RX_PERIODIC: out_ready <= ((tick % 5) > 1);
                default:     out_ready <= 1'b1;
            endcase
        end
    end

    // Result check: a transfer seen at the falling edge completes at the next rising edge.
    always @(negedge clk) begin : result_check
        t_rgba got;
        t_rgba want;
        if (rst_n && out_valid && out_ready) begin
            got = '{out_red, out_green, out_blue, out_alpha};
            if (expected_pixels.size() == 0) begin
                error_count++;
                if (error_count <= 10)
                    $display("Unexpected result r=%0d g=%0d b=%0d a=%0d",
                             got.red, got.green, got.blue, got.alpha);
            end else begin
                want = expected_pixels.pop_front();
                if (got.red !== want.red || got.green !== want.green ||
                    got.blue !== want.blue || got.alpha !== want.alpha) begin
                    error_count++;
                    if (error_count <= 10)
                        $display("Mismatch: exp rgba=%0d,%0d,%0d,%0d got %0d,%0d,%0d,%0d",
                                 want.red, want.green, want.blue, want.alpha,
                                 got.red, got.green, got.blue, got.alpha);
                end
            end
        end
    end

    // Watchdog: cycles with no transfer on either channel.
    always @(negedge clk) begin : watchdog
        int idle_cycles;
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // Test sequence.
    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_table_load();
        test_pass_and_keys();
        test_invert();
        test_grayscale();
        test_palette();
        test_backpressure();
        test_random_phases();
        wait_quiet();
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/ppr_pkg.sv
hdl/ppr_cell.sv
hdl/ppr_post.sv
hdl/pixel_palette_recolor.sv
test/tb_pixel_palette_recolor.sv
